>>> design/c8ie_pkg.sv
// Shared types, constants and tables for the CHIP-8 instruction executor.
// No dependencies; imported by c8ie_ctrl, c8ie_dpath and the top level.
`timescale 1ns / 1ps
package c8ie_pkg;

    localparam int MEM_BYTES     = 4096;
    localparam int MEM_AW        = $clog2(MEM_BYTES);
    localparam int PC_W          = 12;
    localparam logic [PC_W-1:0] PROGRAM_START = 12'h200;
    localparam int FONT_BASE     = 384;
    localparam int FONT_BYTES    = 80;
    localparam int STACK_DEPTH   = 16;
    localparam int SP_W          = $clog2(STACK_DEPTH + 1);
    localparam int STK_AW        = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int SCREEN_W      = 64;
    localparam int SCREEN_H      = 32;
    localparam int FRAME_BYTES   = (SCREEN_W * SCREEN_H) / 8;
    localparam int FRAME_AW      = $clog2(FRAME_BYTES);
    localparam int NREGS         = 16;

    // instruction fields
    localparam logic [3:0]  NIB_SYS  = 4'h0;
    localparam logic [3:0]  NIB_JP   = 4'h1;
    localparam logic [3:0]  NIB_CALL = 4'h2;
    localparam logic [3:0]  NIB_SE   = 4'h3;
    localparam logic [3:0]  NIB_LD   = 4'h6;
    localparam logic [3:0]  NIB_ADD  = 4'h7;
    localparam logic [3:0]  NIB_LDI  = 4'hA;
    localparam logic [3:0]  NIB_RND  = 4'hC;
    localparam logic [3:0]  NIB_DRW  = 4'hD;
    localparam logic [3:0]  NIB_MISC = 4'hF;
    localparam logic [15:0] OP_RET   = 16'h00EE;
    localparam logic [7:0]  KK_GETDT = 8'h07;
    localparam logic [7:0]  KK_SETDT = 8'h15;
    localparam logic [7:0]  KK_FONT  = 8'h29;
    localparam logic [7:0]  KK_BCD   = 8'h33;
    localparam logic [7:0]  KK_LOAD  = 8'h65;
    localparam logic [3:0]  VF_IDX   = 4'hF;

    typedef enum logic [1:0] {
        ITEM_WRITE = 2'd0,
        ITEM_EXEC  = 2'd1,
        ITEM_TICK  = 2'd2,
        ITEM_READ  = 2'd3
    } t_item;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_NOP     = 3'd1,
        ST_UNDER   = 3'd2,
        ST_OVER    = 3'd3,
        ST_UNKNOWN = 3'd4,
        ST_HALTED  = 3'd5
    } t_status;

    typedef enum logic [3:0] {
        IC_RET, IC_NOP, IC_JP, IC_CALL, IC_SE, IC_LD, IC_ADD, IC_LDI,
        IC_RND, IC_DRW, IC_GETDT, IC_SETDT, IC_FONT, IC_BCD, IC_LOAD, IC_BAD
    } t_iclass;

    typedef struct packed {
        logic              take;
        logic              clr_wr;
        logic              host_wr;
        logic              tick;
        logic              fb_rd;
        logic              fb_cap;
        logic              fetch_hi;
        logic              fetch_lo;
        logic              latch_lo;
        logic              exec;
        logic              latch_y;
        logic              row_rd;
        logic              row_line;
        logic              row_wa;
        logic              row_wb;
        logic              bcd_wr;
        logic              ld_rd;
        logic              ld_wr;
        logic              res_load;
        logic [MEM_AW-1:0] step;
    } t_cmd;

    typedef struct packed {
        t_iclass    iclass;
        logic [3:0] x;
        logic [3:0] n;
        logic       ld_stop;
        logic       halted;
    } t_stat;

    localparam logic [7:0] FONT_ROM [FONT_BYTES] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h80, 8'h80, 8'h80, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

endpackage

>>> design/c8ie_ctrl.sv
// Sequencer for the CHIP-8 executor: clearing pass, item dispatch, multi-cycle ops.
// Depends on c8ie_pkg; drives c8ie_dpath through t_cmd and reads t_stat.
`timescale 1ns / 1ps
module c8ie_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [1:0]       i_opcode,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output c8ie_pkg::t_cmd   o_cmd,
    input  c8ie_pkg::t_stat  i_stat
);
    import c8ie_pkg::*;

    typedef enum logic [18:0] {
        S_CLEAR    = 19'h00001,
        S_IDLE     = 19'h00002,
        S_HOSTWR   = 19'h00004,
        S_TICK     = 19'h00008,
        S_FBRD     = 19'h00010,
        S_FBCAP    = 19'h00020,
        S_FETCH_HI = 19'h00040,
        S_FETCH_LO = 19'h00080,
        S_DECODE   = 19'h00100,
        S_DISPATCH = 19'h00200,
        S_DRW_Y    = 19'h00400,
        S_ROW_RD   = 19'h00800,
        S_ROW_A    = 19'h01000,
        S_ROW_WA   = 19'h02000,
        S_ROW_WB   = 19'h04000,
        S_BCD      = 19'h08000,
        S_LD_RD    = 19'h10000,
        S_LD_WR    = 19'h20000,
        S_FINISH   = 19'h40000
    } t_state;

    localparam logic [MEM_AW-1:0] LAST_ADDR = MEM_AW'(MEM_BYTES - 1);

    t_state            r_state, n_state;
    logic [MEM_AW-1:0] r_step, n_step;
    logic              r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_cmd.step  = r_step;
        o_in_ready  = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                n_step       = r_step + 1'b1;
                if (r_step == LAST_ADDR) begin
                    n_state = S_IDLE;
                    n_step  = '0;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_step     = '0;
                    case (i_opcode)
                        ITEM_WRITE: n_state = S_HOSTWR;
                        ITEM_TICK:  n_state = S_TICK;
                        ITEM_READ:  n_state = S_FBRD;
                        default:    n_state = i_stat.halted ? S_FINISH : S_FETCH_HI;
                    endcase
                end
            end
            S_HOSTWR: begin
                o_cmd.host_wr = 1'b1;
                n_state       = S_FINISH;
            end
            S_TICK: begin
                o_cmd.tick = 1'b1;
                n_state    = S_FINISH;
            end
            S_FBRD: begin
                o_cmd.fb_rd = 1'b1;
                n_state     = S_FBCAP;
            end
            S_FBCAP: begin
                o_cmd.fb_cap = 1'b1;
                n_state      = S_FINISH;
            end
            S_FETCH_HI: begin
                o_cmd.fetch_hi = 1'b1;
                n_state        = S_FETCH_LO;
            end
            S_FETCH_LO: begin
                o_cmd.fetch_lo = 1'b1;
                n_state        = S_DECODE;
            end
            S_DECODE: begin
                o_cmd.latch_lo = 1'b1;
                n_state        = S_DISPATCH;
            end
            S_DISPATCH: begin
                o_cmd.exec = 1'b1;
                case (i_stat.iclass)
                    IC_DRW:  n_state = S_DRW_Y;
                    IC_BCD:  n_state = S_BCD;
                    IC_LOAD: n_state = S_LD_RD;
                    default: n_state = S_FINISH;
                endcase
            end
            S_DRW_Y: begin
                o_cmd.latch_y = 1'b1;
                n_state       = (i_stat.n == 4'd0) ? S_FINISH : S_ROW_RD;
            end
            S_ROW_RD: begin
                o_cmd.row_rd = 1'b1;
                n_state      = S_ROW_A;
            end
            S_ROW_A: begin
                o_cmd.row_line = 1'b1;
                n_state        = S_ROW_WA;
            end
            S_ROW_WA: begin
                o_cmd.row_wa = 1'b1;
                n_state      = S_ROW_WB;
            end
            S_ROW_WB: begin
                o_cmd.row_wb = 1'b1;
                n_step       = r_step + 1'b1;
                n_state      = (4'(r_step[3:0] + 4'd1) == i_stat.n) ? S_FINISH : S_ROW_RD;
            end
            S_BCD: begin
                o_cmd.bcd_wr = 1'b1;
                n_step       = r_step + 1'b1;
                if (r_step[1:0] == 2'd2) begin
                    n_state = S_FINISH;
                end
            end
            S_LD_RD: begin
                if (i_stat.ld_stop) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.ld_rd = 1'b1;
                    n_state     = S_LD_WR;
                end
            end
            S_LD_WR: begin
                o_cmd.ld_wr = 1'b1;
                if (r_step[3:0] == i_stat.x) begin
                    n_state = S_FINISH;
                end else begin
                    n_step  = r_step + 1'b1;
                    n_state = S_LD_RD;
                end
            end
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.res_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

>>> design/c8ie_dpath.sv
// Datapath of the CHIP-8 executor: program memory, framebuffer, V registers,
// stack, timers and result register. Depends on c8ie_pkg; commanded by c8ie_ctrl.
`timescale 1ns / 1ps
module c8ie_dpath (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  c8ie_pkg::t_cmd          i_cmd,
    output c8ie_pkg::t_stat         o_stat,
    input  logic [1:0]              i_opcode,
    input  logic [11:0]             i_addr,
    input  logic [7:0]              i_data,
    input  logic [7:0]              i_rand_byte,
    output logic [2:0]              o_status,
    output logic [11:0]             o_pc,
    output logic [11:0]             o_index_value,
    output logic                    o_display_changed,
    output logic [7:0]              o_read_byte,
    output logic [7:0]              o_delay_value,
    output logic                    o_halted_flag
);
    import c8ie_pkg::*;

    // storage
    logic [7:0]      r_mem [MEM_BYTES];
    logic [7:0]      r_mem_q;
    logic [7:0]      r_fb [FRAME_BYTES];
    logic            r_fb_vld [FRAME_BYTES];
    logic [7:0]      r_fb_q;
    logic            r_fb_qv;
    logic [7:0]      r_v [NREGS];
    logic [PC_W-1:0] r_stk [STACK_DEPTH];

    // architectural and per-item state
    logic [PC_W-1:0] r_pc, r_i;
    logic [SP_W-1:0] r_sp;
    logic [7:0]      r_delay;
    logic            r_halted;
    logic [15:0]     r_op;
    logic [7:0]      r_x0, r_y0, r_line;
    logic [11:0]     r_addr;
    logic [7:0]      r_data, r_rand;
    t_status         r_st;
    logic            r_drew;
    logic [7:0]      r_rb;

    // result register
    t_status         r_out_status;
    logic [11:0]     r_out_pc, r_out_i;
    logic            r_out_drew, r_out_halted;
    logic [7:0]      r_out_rb, r_out_delay;

    // decode
    t_iclass    iclass;
    logic [3:0] op_x, op_y, op_n;
    logic [7:0] op_kk;
    logic [PC_W-1:0] op_nnn, pc_next, pc_skip;

    assign op_x    = r_op[11:8];
    assign op_y    = r_op[7:4];
    assign op_n    = r_op[3:0];
    assign op_kk   = r_op[7:0];
    assign op_nnn  = r_op[11:0];
    assign pc_next = r_pc + 12'd2;
    assign pc_skip = r_pc + 12'd4;

    always_comb begin
        case (r_op[15:12])
            NIB_SYS:  iclass = (r_op == OP_RET) ? IC_RET : IC_NOP;
            NIB_JP:   iclass = IC_JP;
            NIB_CALL: iclass = IC_CALL;
            NIB_SE:   iclass = IC_SE;
            NIB_LD:   iclass = IC_LD;
            NIB_ADD:  iclass = IC_ADD;
            NIB_LDI:  iclass = IC_LDI;
            NIB_RND:  iclass = IC_RND;
            NIB_DRW:  iclass = IC_DRW;
            NIB_MISC: begin
                case (op_kk)
                    KK_GETDT: iclass = IC_GETDT;
                    KK_SETDT: iclass = IC_SETDT;
                    KK_FONT:  iclass = IC_FONT;
                    KK_BCD:   iclass = IC_BCD;
                    KK_LOAD:  iclass = IC_LOAD;
                    default:  iclass = IC_BAD;
                endcase
            end
            default:  iclass = IC_BAD;
        endcase
    end

    // single register read port: Vy only while latching the draw origin
    logic [7:0] rv;
    assign rv = r_v[i_cmd.latch_y ? op_y : op_x];

    // Fx65 end-of-memory stop
    logic [MEM_AW:0] ld_sum;
    assign ld_sum = (MEM_AW+1)'(r_i) + (MEM_AW+1)'(i_cmd.step);

    assign o_stat.iclass  = iclass;
    assign o_stat.x       = op_x;
    assign o_stat.n       = op_n;
    assign o_stat.ld_stop = (32'(ld_sum) >= 32'(MEM_BYTES));
    assign o_stat.halted  = r_halted;

    // BCD digits: compare-subtract for hundreds, reciprocal multiply for tens
    logic [1:0]  bcd_h;
    logic [7:0]  bcd_rem;
    logic [14:0] bcd_prod;
    logic [3:0]  bcd_t, bcd_o;
    logic [7:0]  bcd_digit;

    always_comb begin
        bcd_h    = (rv >= 8'd200) ? 2'd2 : ((rv >= 8'd100) ? 2'd1 : 2'd0);
        bcd_rem  = rv - (8'(bcd_h) * 8'd100);
        bcd_prod = 15'(bcd_rem) * 15'd205;
        bcd_t    = bcd_prod[14:11];
        bcd_o    = 4'(bcd_rem - (8'(bcd_t) * 8'd10));
        case (i_cmd.step[1:0])
            2'd0:    bcd_digit = 8'(bcd_h);
            2'd1:    bcd_digit = 8'(bcd_t);
            default: bcd_digit = 8'(bcd_o);
        endcase
    end

    // program memory ports
    logic [MEM_AW-1:0] idx_addr, mem_ra, mem_wa;
    logic [7:0]        mem_wd, clr_byte;
    logic              mem_we;

    assign idx_addr = MEM_AW'(r_i) + i_cmd.step;

    always_comb begin
        if ((32'(i_cmd.step) >= FONT_BASE) && (32'(i_cmd.step) < FONT_BASE + FONT_BYTES)) begin
            clr_byte = FONT_ROM[7'(32'(i_cmd.step) - FONT_BASE)];
        end else begin
            clr_byte = 8'd0;
        end
    end

    always_comb begin
        if (i_cmd.fetch_lo) begin
            mem_ra = MEM_AW'(r_pc + 12'd1);
        end else if (i_cmd.row_rd || i_cmd.ld_rd) begin
            mem_ra = idx_addr;
        end else begin
            mem_ra = MEM_AW'(r_pc);
        end
        mem_we = i_cmd.clr_wr || i_cmd.host_wr || i_cmd.bcd_wr;
        if (i_cmd.clr_wr) begin
            mem_wa = i_cmd.step;
            mem_wd = clr_byte;
        end else if (i_cmd.host_wr) begin
            mem_wa = MEM_AW'(r_addr);
            mem_wd = r_data;
        end else begin
            mem_wa = idx_addr;
            mem_wd = bcd_digit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_mem_q <= r_mem[mem_ra];
    end

    // framebuffer: LSB of a byte is the leftmost pixel
    logic [4:0]          row_y;
    logic [FRAME_AW-1:0] fb_a, fb_b, fb_ra, fb_wa;
    logic [7:0]          line_rev, fb_cur, fb_wd, pat_byte;
    logic [15:0]         pat;
    logic                fb_we, coll;

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            line_rev[k] = r_line[7-k];
        end
    end

    assign row_y    = r_y0[4:0] + i_cmd.step[4:0];
    assign fb_a     = {row_y, r_x0[5:3]};
    assign fb_b     = {row_y, 3'(r_x0[5:3] + 3'd1)};
    assign pat      = {8'd0, line_rev} << r_x0[2:0];
    assign pat_byte = i_cmd.row_wb ? pat[15:8] : pat[7:0];
    assign fb_cur   = r_fb_qv ? r_fb_q : 8'd0;
    assign fb_we    = i_cmd.row_wa || i_cmd.row_wb;
    assign fb_wa    = i_cmd.row_wb ? fb_b : fb_a;
    assign fb_wd    = fb_cur ^ pat_byte;
    assign coll     = fb_we && ((fb_cur & pat_byte) != 8'd0);

    always_comb begin
        if (i_cmd.row_line) begin
            fb_ra = fb_a;
        end else if (i_cmd.row_wa) begin
            fb_ra = fb_b;
        end else begin
            fb_ra = r_addr[FRAME_AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (fb_we) begin
            r_fb[fb_wa] <= fb_wd;
        end
        r_fb_q <= r_fb[fb_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < FRAME_BYTES; k++) begin
                r_fb_vld[k] <= 1'b0;
            end
            r_fb_qv <= 1'b0;
        end else begin
            if (fb_we) begin
                r_fb_vld[fb_wa] <= 1'b1;
            end
            r_fb_qv <= r_fb_vld[fb_ra];
        end
    end

    // V register write port
    logic       v_we;
    logic [3:0] v_wa;
    logic [7:0] v_wd;

    always_comb begin
        v_we = 1'b0;
        v_wa = op_x;
        v_wd = op_kk;
        if (i_cmd.exec) begin
            case (iclass)
                IC_LD:    v_we = 1'b1;
                IC_ADD: begin
                    v_we = 1'b1;
                    v_wd = rv + op_kk;
                end
                IC_RND: begin
                    v_we = 1'b1;
                    v_wd = r_rand & op_kk;
                end
                IC_GETDT: begin
                    v_we = 1'b1;
                    v_wd = r_delay;
                end
                default:  v_we = 1'b0;
            endcase
        end else if (i_cmd.latch_y) begin
            // VF clears only once both draw coordinates are latched
            v_we = 1'b1;
            v_wa = VF_IDX;
            v_wd = 8'd0;
        end else if (coll) begin
            v_we = 1'b1;
            v_wa = VF_IDX;
            v_wd = 8'd1;
        end else if (i_cmd.ld_wr) begin
            v_we = 1'b1;
            v_wa = i_cmd.step[3:0];
            v_wd = r_mem_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NREGS; k++) begin
                r_v[k] <= 8'd0;
            end
        end else if (v_we) begin
            r_v[v_wa] <= v_wd;
        end
    end

    // call stack
    logic stk_full, stk_empty;
    assign stk_full  = (r_sp == SP_W'(STACK_DEPTH));
    assign stk_empty = (r_sp == '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && iclass == IC_CALL && !stk_full) begin
            r_stk[r_sp[STK_AW-1:0]] <= pc_next;
        end
    end

    // payload latches
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_addr <= i_addr;
            r_data <= i_data;
            r_rand <= i_rand_byte;
        end
        if (i_cmd.fetch_lo) begin
            r_op[15:8] <= r_mem_q;
        end
        if (i_cmd.latch_lo) begin
            r_op[7:0] <= r_mem_q;
        end
        if (i_cmd.exec) begin
            r_x0 <= rv;
        end
        if (i_cmd.latch_y) begin
            r_y0 <= rv;
        end
        if (i_cmd.row_line) begin
            r_line <= r_mem_q;
        end
    end

    // architectural state and per-item status
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc     <= PROGRAM_START;
            r_i      <= '0;
            r_sp     <= '0;
            r_delay  <= 8'd0;
            r_halted <= 1'b0;
            r_st     <= ST_OK;
            r_drew   <= 1'b0;
            r_rb     <= 8'd0;
        end else begin
            if (i_cmd.take) begin
                r_st   <= (i_opcode == ITEM_EXEC && r_halted) ? ST_HALTED : ST_OK;
                r_drew <= 1'b0;
                r_rb   <= 8'd0;
            end
            if (i_cmd.tick && r_delay != 8'd0) begin
                r_delay <= r_delay - 8'd1;
            end
            if (i_cmd.fb_cap && r_addr[11:FRAME_AW] == '0) begin
                r_rb <= fb_cur;
            end
            if (i_cmd.exec) begin
                case (iclass)
                    IC_RET: begin
                        if (stk_empty) begin
                            r_st     <= ST_UNDER;
                            r_halted <= 1'b1;
                        end else begin
                            r_sp <= r_sp - 1'b1;
                            r_pc <= r_stk[STK_AW'(r_sp - 1'b1)];
                        end
                    end
                    IC_NOP: begin
                        r_pc <= pc_next;
                        r_st <= ST_NOP;
                    end
                    IC_JP:  r_pc <= op_nnn;
                    IC_CALL: begin
                        if (stk_full) begin
                            r_st     <= ST_OVER;
                            r_halted <= 1'b1;
                        end else begin
                            r_sp <= r_sp + 1'b1;
                            r_pc <= op_nnn;
                        end
                    end
                    IC_SE:  r_pc <= (rv == op_kk) ? pc_skip : pc_next;
                    IC_LDI: begin
                        r_i  <= op_nnn;
                        r_pc <= pc_next;
                    end
                    IC_SETDT: begin
                        r_delay <= rv;
                        r_pc    <= pc_next;
                    end
                    IC_FONT: begin
                        r_i  <= 12'(FONT_BASE) + 12'(rv[3:0]) * 12'd5;
                        r_pc <= pc_next;
                    end
                    IC_DRW: begin
                        r_drew <= 1'b1;
                        r_pc   <= pc_next;
                    end
                    IC_BAD: begin
                        r_st     <= ST_UNKNOWN;
                        r_halted <= 1'b1;
                    end
                    default: r_pc <= pc_next;
                endcase
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_out_status <= r_st;
            r_out_pc     <= r_pc;
            r_out_i      <= r_i;
            r_out_drew   <= r_drew;
            r_out_rb     <= r_rb;
            r_out_delay  <= r_delay;
            r_out_halted <= r_halted;
        end
    end

    assign o_status          = r_out_status;
    assign o_pc              = r_out_pc;
    assign o_index_value     = r_out_i;
    assign o_display_changed = r_out_drew;
    assign o_read_byte       = r_out_rb;
    assign o_delay_value     = r_out_delay;
    assign o_halted_flag     = r_out_halted;

endmodule

>>> design/chip8_instruction_executor_core.sv
// Top level of the CHIP-8 instruction executor: controller plus datapath.
// Depends on c8ie_pkg, c8ie_ctrl and c8ie_dpath.
`timescale 1ns / 1ps
// CHIP-8 subset executor. Each input transaction is one item: write a byte
// of program memory, execute the instruction at PC, tick the delay timer, or
// read a framebuffer byte; each item yields exactly one output transaction
// with status, PC, I, delay timer, halted flag, a draw flag and the read byte.
// After reset the block runs a clearing pass (one memory byte per cycle,
// loading the hex font at 0x180) and takes no item until it ends. Items
// run one at a time through a shared program memory and a framebuffer RAM,
// each with one read and one write port; a Dxyn item works through its
// sprite rows one after another, since every sprite row needs a memory
// read and two read-modify-write framebuffer accesses. The result sits in
// an output register, so the next item is taken while a result still
// waits for ready.
// Stack faults and unknown opcodes set the halted flag; later execute items
// report status 5 while write, tick and read items still work.
module chip8_instruction_executor_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_opcode,
    input  logic [11:0] i_addr,
    input  logic [7:0]  i_data,
    input  logic [7:0]  i_rand_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    output logic [11:0] o_pc,
    output logic [11:0] o_index_value,
    output logic        o_display_changed,
    output logic [7:0]  o_read_byte,
    output logic [7:0]  o_delay_value,
    output logic        o_halted_flag
);
    import c8ie_pkg::*;

    t_cmd  cmd;   // per-cycle datapath commands
    t_stat stat;  // decode and loop status back to the sequencer

    c8ie_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_opcode    (i_opcode),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    c8ie_dpath u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_opcode          (i_opcode),
        .i_addr            (i_addr),
        .i_data            (i_data),
        .i_rand_byte       (i_rand_byte),
        .o_status          (o_status),
        .o_pc              (o_pc),
        .o_index_value     (o_index_value),
        .o_display_changed (o_display_changed),
        .o_read_byte       (o_read_byte),
        .o_delay_value     (o_delay_value),
        .o_halted_flag     (o_halted_flag)
    );

endmodule
